>>> rtl/scpr_pkg.sv
// Shared types, constants and codes of the scanline polygon coverage rasterizer.
package scpr_pkg;

    localparam int DEF_MAX_POINTS     = 256;
    localparam int DEF_NODES_PER_LINE = 64;
    localparam int DEF_SPAN_WIDTH     = 256;
    localparam int NODE_LINES         = 32;
    localparam int MAX_CHUNKS         = 32;

    localparam int CMD_W   = 2;
    localparam int COORD_W = 20;
    localparam int ROW_W   = 10;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 11;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RENDER = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_AA_LEVEL = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_CLIP_X   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_CLIP_Y   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_CLIP_W   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_CLIP_H   = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_CLR, OP_LINE, OP_SCAN_RD, OP_SCAN_HIT, OP_SCAN_NEXT,
        OP_EDGE_RD, OP_EDGE_LD, OP_EDGE_GEO, OP_EDGE_HIT, OP_MUL1, OP_MUL2, OP_MUL3,
        OP_SUM, OP_DIV_INIT, OP_DIV, OP_SAT, OP_INS_RD, OP_INS_SHIFT, OP_INS_PUT,
        OP_EDGE_NEXT, OP_SP_RD0, OP_SP_RD1, OP_SP_CLAMP, OP_PIX_RD, OP_PIX_WR,
        OP_SP_NEXT, OP_LINE_END, OP_OUT_RD, OP_OUT_ACC, OP_OUT_NEXT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLR, ST_LINE, ST_SCAN_CHK, ST_SCAN_WAIT, ST_EDGE_RD, ST_EDGE_LD,
        ST_EDGE_GEO, ST_EDGE_HIT, ST_MUL1, ST_MUL2, ST_MUL3, ST_SUM, ST_DIV_INIT,
        ST_DIV, ST_SAT, ST_INS_CHK, ST_INS_CMP, ST_EDGE_NEXT, ST_SP_CHK, ST_SP_RD1,
        ST_SP_CLAMP, ST_PIX_CHK, ST_PIX_WR, ST_LINE_END, ST_OUT_RD, ST_OUT_ACC,
        ST_OUT_SHOW
    } state_t;

    typedef struct packed {
        logic render_go;
        logic clr_last;
        logic scan_in;
        logic mark;
        logic hit;
        logic div_done;
        logic cr_full;
        logic ins_zero;
        logic ins_gt;
        logic edge_last;
        logic pair_ok;
        logic pix_ok;
        logic last_sub;
        logic byte_last;
        logic chunk_last;
    } dp_status_t;

endpackage

>>> rtl/scpr_ctrl.sv
// Controller state machine of the rasterizer: sequences the datapath operations.
module scpr_ctrl import scpr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_op_t     op
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_valid && status.render_go) state_next = ST_CLR;
            ST_CLR:       if (status.clr_last) state_next = ST_LINE;
            ST_LINE:      state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:  state_next = status.scan_in ? ST_SCAN_WAIT : ST_SP_CHK;
            ST_SCAN_WAIT: state_next = status.mark ? ST_EDGE_RD : ST_SCAN_CHK;
            ST_EDGE_RD:   state_next = ST_EDGE_LD;
            ST_EDGE_LD:   state_next = ST_EDGE_GEO;
            ST_EDGE_GEO:  state_next = ST_EDGE_HIT;
            ST_EDGE_HIT:  state_next = ST_MUL1;
            ST_MUL1:      state_next = status.hit ? ST_MUL2 : ST_EDGE_NEXT;
            ST_MUL2:      state_next = ST_MUL3;
            ST_MUL3:      state_next = ST_SUM;
            ST_SUM:       state_next = ST_DIV_INIT;
            ST_DIV_INIT:  state_next = ST_DIV;
            ST_DIV:       if (status.div_done) state_next = ST_SAT;
            ST_SAT:       state_next = status.cr_full ? ST_EDGE_NEXT : ST_INS_CHK;
            ST_INS_CHK:   state_next = status.ins_zero ? ST_EDGE_NEXT : ST_INS_CMP;
            ST_INS_CMP:   state_next = status.ins_gt ? ST_INS_CHK : ST_EDGE_NEXT;
            ST_EDGE_NEXT: state_next = status.edge_last ? ST_SCAN_CHK : ST_EDGE_RD;
            ST_SP_CHK:    state_next = status.pair_ok ? ST_SP_RD1 : ST_LINE_END;
            ST_SP_RD1:    state_next = ST_SP_CLAMP;
            ST_SP_CLAMP:  state_next = ST_PIX_CHK;
            ST_PIX_CHK:   state_next = status.pix_ok ? ST_PIX_WR : ST_SP_CHK;
            ST_PIX_WR:    state_next = ST_PIX_CHK;
            ST_LINE_END:  state_next = status.last_sub ? ST_OUT_RD : ST_LINE;
            ST_OUT_RD:    state_next = ST_OUT_ACC;
            ST_OUT_ACC:   state_next = status.byte_last ? ST_OUT_SHOW : ST_OUT_RD;
            ST_OUT_SHOW: begin
                if (m_ready) state_next = status.chunk_last ? ST_IDLE : ST_OUT_RD;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        op      = OP_NONE;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) op = OP_ACCEPT;
            end
            ST_CLR:       op = OP_CLR;
            ST_LINE:      op = OP_LINE;
            ST_SCAN_CHK:  op = OP_SCAN_RD;
            ST_SCAN_WAIT: op = status.mark ? OP_SCAN_HIT : OP_SCAN_NEXT;
            ST_EDGE_RD:   op = OP_EDGE_RD;
            ST_EDGE_LD:   op = OP_EDGE_LD;
            ST_EDGE_GEO:  op = OP_EDGE_GEO;
            ST_EDGE_HIT:  op = OP_EDGE_HIT;
            ST_MUL1:      op = status.hit ? OP_MUL1 : OP_NONE;
            ST_MUL2:      op = OP_MUL2;
            ST_MUL3:      op = OP_MUL3;
            ST_SUM:       op = OP_SUM;
            ST_DIV_INIT:  op = OP_DIV_INIT;
            ST_DIV:       op = OP_DIV;
            ST_SAT:       op = OP_SAT;
            ST_INS_CHK:   op = status.ins_zero ? OP_INS_PUT : OP_INS_RD;
            ST_INS_CMP:   op = status.ins_gt ? OP_INS_SHIFT : OP_INS_PUT;
            ST_EDGE_NEXT: op = OP_EDGE_NEXT;
            ST_SP_CHK:    op = status.pair_ok ? OP_SP_RD0 : OP_NONE;
            ST_SP_RD1:    op = OP_SP_RD1;
            ST_SP_CLAMP:  op = OP_SP_CLAMP;
            ST_PIX_CHK:   op = status.pix_ok ? OP_PIX_RD : OP_SP_NEXT;
            ST_PIX_WR:    op = OP_PIX_WR;
            ST_LINE_END:  op = OP_LINE_END;
            ST_OUT_RD:    op = OP_OUT_RD;
            ST_OUT_ACC:   op = OP_OUT_ACC;
            ST_OUT_SHOW: begin
                m_valid = 1'b1;
                if (m_ready) op = OP_OUT_NEXT;
            end
            default:      op = OP_NONE;
        endcase
    end

endmodule

>>> rtl/scpr_datapath.sv
// Datapath of the rasterizer: registers, outline, crossing and coverage memories, divider.
module scpr_datapath import scpr_pkg::*; #(
    parameter int MAX_POINTS     = DEF_MAX_POINTS,
    parameter int NODES_PER_LINE = DEF_NODES_PER_LINE,
    parameter int SPAN_WIDTH     = DEF_SPAN_WIDTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IW-1:0]         cfg_index,
    input  logic [CFG_DW-1:0]         cfg_data,
    input  logic [CMD_W-1:0]          s_command,
    input  logic signed [COORD_W-1:0] s_point_x,
    input  logic signed [COORD_W-1:0] s_point_y,
    input  logic                      s_path_end,
    input  logic [ROW_W-1:0]          s_row_index,
    input  dp_op_t                    op,
    output dp_status_t                status,
    output logic [63:0]               m_alpha_bytes,
    output logic [4:0]                m_chunk_index,
    output logic                      m_last_chunk
);

    localparam int PT_AW     = $clog2(MAX_POINTS);
    localparam int PT_CW     = $clog2(MAX_POINTS + 1);
    localparam int CR_AW     = $clog2(NODES_PER_LINE);
    localparam int CR_CW     = $clog2(NODES_PER_LINE + 1);
    localparam int COV_DEPTH = (SPAN_WIDTH < MAX_CHUNKS * 8) ? SPAN_WIDTH : MAX_CHUNKS * 8;
    localparam int COV_AW    = $clog2(COV_DEPTH);
    localparam int WW        = $clog2(COV_DEPTH + 1);

    // Configuration registers.
    logic [2:0]  aa_level_reg;
    logic [10:0] clip_x_reg, clip_y_reg, clip_h_reg;
    logic [8:0]  clip_w_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aa_level_reg <= 3'd1;
            clip_x_reg   <= '0;
            clip_y_reg   <= '0;
            clip_w_reg   <= '0;
            clip_h_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_AA_LEVEL: aa_level_reg <= cfg_data[2:0];
                CFG_CLIP_X:   clip_x_reg   <= cfg_data;
                CFG_CLIP_Y:   clip_y_reg   <= cfg_data;
                CFG_CLIP_W:   clip_w_reg   <= cfg_data[8:0];
                CFG_CLIP_H:   clip_h_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Render setup decoded from the registers and the row being accepted.
    logic [1:0]    shift_c;
    logic [WW-1:0] w_c;
    logic [4:0]    sh_mask;
    logic [ROW_W-1:0] row_strip;
    logic [11:0]   strip_pix;

    always_comb begin
        case (aa_level_reg)
            3'd2:    shift_c = 2'd1;
            3'd4:    shift_c = 2'd2;
            default: shift_c = 2'd0;
        endcase
        w_c       = (clip_w_reg > 9'(COV_DEPTH)) ? WW'(COV_DEPTH) : WW'(clip_w_reg);
        sh_mask   = 5'h1F >> shift_c;
        row_strip = {s_row_index[9:5], s_row_index[4:0] & ~sh_mask};
        strip_pix = {1'b0, clip_y_reg} + {2'b0, row_strip};
    end

    logic [1:0]    shift_reg;
    logic [WW-1:0] w_reg;
    logic [4:0]    chunk_last_reg;
    logic [19:0]   strip_reg;
    logic [4:0]    kbase_reg, k_reg;
    logic [1:0]    sub_reg;
    logic [8:0]    w_m1;

    assign w_m1 = 9'(w_c) - 9'd1;

    // Outline memories.
    logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
    logic signed [COORD_W-1:0] mem_y [MAX_POINTS];
    logic                      mem_m [MAX_POINTS];
    logic signed [COORD_W-1:0] rd_x, rd_y;
    logic                      rd_m;
    logic [PT_CW-1:0] point_total_reg, scan_ptr_reg, start_reg, end_reg, j_reg;
    logic [PT_AW-1:0] pt_raddr;
    logic             pt_we;

    assign pt_we    = (op == OP_ACCEPT) && (s_command == CMD_LOAD) &&
                      (point_total_reg != PT_CW'(MAX_POINTS));
    assign pt_raddr = (op == OP_SCAN_RD) ? scan_ptr_reg[PT_AW-1:0] : j_reg[PT_AW-1:0];

    always_ff @(posedge aclk) begin
        if (pt_we) begin
            mem_x[point_total_reg[PT_AW-1:0]] <= s_point_x;
            mem_y[point_total_reg[PT_AW-1:0]] <= s_point_y;
            mem_m[point_total_reg[PT_AW-1:0]] <= s_path_end;
        end
        rd_x <= mem_x[pt_raddr];
        rd_y <= mem_y[pt_raddr];
        rd_m <= mem_m[pt_raddr];
    end

    // Edge geometry.
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic signed [COORD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic                      horiz_reg, hit_reg;
    logic [20:0]               d_reg;
    logic signed [20:0]        dx_reg;
    logic signed [21:0]        syr_reg, eyr_reg, c_reg;
    logic [4:0]                n_reg;
    logic signed [41:0]        p1_reg;
    logic signed [42:0]        p2_reg;
    logic signed [26:0]        p3_reg;
    logic signed [47:0]        num_reg;
    logic                      neg_reg;
    logic [39:0]               dq_reg;
    logic [20:0]               rem_reg;
    logic [5:0]                div_cnt_reg;
    logic signed [15:0]        v_reg;

    logic [13:0]        yk;
    logic signed [21:0] yk_s, syc, kf_num, strip_s;
    logic [7:0]         half;
    logic [8:0]         step;
    logic [3:0]         lsh;
    logic [4:0]         kfirst;
    logic               hit_c;
    logic [47:0]        mag;
    logic [48:0]        n49;
    logic [21:0]        rsh;
    logic               ge;
    logic [15:0]        sat_c;

    always_comb begin
        lsh     = 4'd8 - {2'b0, shift_reg};
        half    = 8'd128 >> shift_reg;
        step    = 9'd256 >> shift_reg;
        yk      = ({9'b0, k_reg} << lsh) + {6'b0, half};
        yk_s    = $signed({8'b0, yk});
        strip_s = $signed({2'b0, strip_reg});
        hit_c   = !horiz_reg && (yk_s >= syr_reg) && (yk_s < eyr_reg);
        syc     = syr_reg[21] ? 22'sd0 : syr_reg;
        kf_num  = syc - $signed({14'b0, half}) + $signed({13'b0, step}) - 22'sd1;
        kfirst  = (syc <= $signed({14'b0, half})) ? 5'd0 : 5'(kf_num >>> lsh);
        mag     = num_reg[47] ? 48'(-num_reg) : 48'(num_reg);
        n49     = {mag, 1'b0} + {20'b0, d_reg, 8'b0};
        rsh     = {rem_reg, dq_reg[39]};
        ge      = rsh >= {1'b0, d_reg};
        if (neg_reg) begin
            sat_c = (dq_reg > 40'd32768) ? 16'h8000 : 16'(-dq_reg[15:0]);
        end else begin
            sat_c = (dq_reg > 40'd32767) ? 16'h7FFF : dq_reg[15:0];
        end
    end

    // Crossing memory, kept sorted by insertion.
    logic signed [15:0] cr_mem [NODES_PER_LINE];
    logic signed [15:0] cr_rd, cr_wdata, lo_reg;
    logic [CR_CW-1:0]   cnt_reg, ins_j_reg, pp_reg, pp_n, ins_m1;
    logic [CR_AW-1:0]   cr_raddr;
    logic               cr_we;

    assign pp_n   = pp_reg + 1'b1;
    assign ins_m1 = ins_j_reg - 1'b1;

    always_comb begin
        cr_we    = (op == OP_INS_SHIFT) || (op == OP_INS_PUT);
        cr_wdata = (op == OP_INS_SHIFT) ? cr_rd : v_reg;
        case (op)
            OP_INS_RD: cr_raddr = ins_m1[CR_AW-1:0];
            OP_SP_RD1: cr_raddr = pp_n[CR_AW-1:0];
            default:   cr_raddr = pp_reg[CR_AW-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cr_we) cr_mem[ins_j_reg[CR_AW-1:0]] <= cr_wdata;
        cr_rd <= cr_mem[cr_raddr];
    end

    // Span clamping and coverage accumulation.
    logic [12:0]        cxa;
    logic [10:0]        lim, u_reg, x2_reg, seg_reg, pix_e;
    logic signed [17:0] x1_s, x2_s;
    logic [10:0]        x1_c, x2_c, pix_c;
    logic [COV_AW-1:0]  pix_reg, clr_reg;

    function automatic logic [10:0] clamp_x(input logic signed [17:0] x,
                                            input logic [10:0] hi);
        if (x[17]) return 11'd0;
        if (x > $signed({7'b0, hi})) return hi;
        return x[10:0];
    endfunction

    always_comb begin
        cxa   = {2'b0, clip_x_reg} << shift_reg;
        lim   = 11'(w_reg) << shift_reg;
        x1_s  = $signed({{2{lo_reg[15]}}, lo_reg}) - $signed({5'b0, cxa});
        x2_s  = $signed({{2{cr_rd[15]}}, cr_rd}) - $signed({5'b0, cxa});
        x1_c  = clamp_x(x1_s, lim);
        x2_c  = clamp_x(x2_s, lim);
        pix_c = u_reg >> shift_reg;
        pix_e = (pix_c + 11'd1) << shift_reg;
    end

    // Coverage memory.
    logic [4:0]        cov_mem [COV_DEPTH];
    logic [4:0]        cov_rd, cov_wdata;
    logic [COV_AW-1:0] cov_raddr, cov_waddr;
    logic              cov_we;
    logic [4:0]        out_p_reg;
    logic [2:0]        out_b_reg;
    logic [7:0]        px;
    logic [63:0]       word_reg;

    assign px = {out_p_reg, out_b_reg};

    always_comb begin
        cov_we    = (op == OP_CLR) || (op == OP_PIX_WR);
        cov_waddr = (op == OP_CLR) ? clr_reg : pix_reg;
        cov_wdata = (op == OP_CLR) ? 5'd0 : cov_rd + 5'(seg_reg - u_reg);
        cov_raddr = (op == OP_OUT_RD) ? px[COV_AW-1:0] : pix_c[COV_AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cov_we) cov_mem[cov_waddr] <= cov_wdata;
        cov_rd <= cov_mem[cov_raddr];
    end

    function automatic logic [7:0] alpha_of(input logic [4:0] cnt, input logic [1:0] sh);
        logic [4:0] full;
        logic [3:0] amt;
        full = 5'd1 << {sh, 1'b0};
        amt  = 4'd8 - {1'b0, sh, 1'b0};
        if (cnt >= full) return 8'd255;
        return 8'({3'b0, cnt} << amt);
    endfunction

    // Sequenced datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_total_reg <= '0;
        end else if (op == OP_ACCEPT) begin
            if (s_command == CMD_CLEAR) point_total_reg <= '0;
            else if (pt_we) point_total_reg <= point_total_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            OP_ACCEPT: begin
                shift_reg      <= shift_c;
                w_reg          <= w_c;
                chunk_last_reg <= w_m1[7:3];
                strip_reg      <= {strip_pix, 8'b0};
                kbase_reg      <= (s_row_index[4:0] & sh_mask) << shift_c;
                sub_reg        <= '0;
                clr_reg        <= '0;
                out_p_reg      <= '0;
                out_b_reg      <= '0;
                word_reg       <= '0;
            end
            OP_CLR: clr_reg <= clr_reg + 1'b1;
            OP_LINE: begin
                k_reg        <= kbase_reg + {3'b0, sub_reg};
                cnt_reg      <= '0;
                pp_reg       <= '0;
                scan_ptr_reg <= '0;
                start_reg    <= '0;
            end
            OP_SCAN_HIT: begin
                prev_x_reg <= rd_x;
                prev_y_reg <= rd_y;
                end_reg    <= scan_ptr_reg;
                j_reg      <= start_reg;
            end
            OP_SCAN_NEXT: scan_ptr_reg <= scan_ptr_reg + 1'b1;
            OP_EDGE_LD: begin
                cur_x_reg <= rd_x;
                cur_y_reg <= rd_y;
                horiz_reg <= (prev_y_reg == rd_y);
                if (prev_y_reg < rd_y) begin
                    sx_reg <= prev_x_reg; sy_reg <= prev_y_reg;
                    ex_reg <= rd_x;       ey_reg <= rd_y;
                end else begin
                    sx_reg <= rd_x;       sy_reg <= rd_y;
                    ex_reg <= prev_x_reg; ey_reg <= prev_y_reg;
                end
            end
            OP_EDGE_GEO: begin
                d_reg   <= 21'({ey_reg[19], ey_reg} - {sy_reg[19], sy_reg});
                dx_reg  <= $signed({ex_reg[19], ex_reg}) - $signed({sx_reg[19], sx_reg});
                syr_reg <= $signed({{2{sy_reg[19]}}, sy_reg}) - strip_s;
                eyr_reg <= $signed({{2{ey_reg[19]}}, ey_reg}) - strip_s;
            end
            OP_EDGE_HIT: begin
                hit_reg <= hit_c;
                c_reg   <= syr_reg[21] ? -syr_reg : 22'sd0;
                n_reg   <= k_reg - kfirst;
            end
            OP_MUL1: p1_reg <= sx_reg * $signed({1'b0, d_reg});
            OP_MUL2: p2_reg <= dx_reg * c_reg;
            OP_MUL3: p3_reg <= $signed({1'b0, n_reg}) * dx_reg;
            OP_SUM: begin
                num_reg <= (($signed({{6{p1_reg[41]}}, p1_reg}) +
                             $signed({{5{p2_reg[42]}}, p2_reg})) <<< shift_reg) +
                           ($signed({{21{p3_reg[26]}}, p3_reg}) <<< 8);
            end
            OP_DIV_INIT: begin
                neg_reg     <= num_reg[47];
                dq_reg      <= n49[48:9];
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            OP_DIV: begin
                rem_reg     <= ge ? 21'(rsh - {1'b0, d_reg}) : rsh[20:0];
                dq_reg      <= {dq_reg[38:0], ge};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            OP_SAT: begin
                v_reg     <= sat_c;
                ins_j_reg <= cnt_reg;
            end
            OP_INS_SHIFT: ins_j_reg <= ins_m1;
            OP_INS_PUT: cnt_reg <= cnt_reg + 1'b1;
            OP_EDGE_NEXT: begin
                prev_x_reg <= cur_x_reg;
                prev_y_reg <= cur_y_reg;
                if (j_reg == end_reg) begin
                    start_reg    <= end_reg + 1'b1;
                    scan_ptr_reg <= end_reg + 1'b1;
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            OP_SP_RD1: lo_reg <= cr_rd;
            OP_SP_CLAMP: begin
                u_reg  <= x1_c;
                x2_reg <= x2_c;
            end
            OP_PIX_RD: begin
                pix_reg <= pix_c[COV_AW-1:0];
                seg_reg <= (pix_e < x2_reg) ? pix_e : x2_reg;
            end
            OP_PIX_WR: u_reg <= seg_reg;
            OP_SP_NEXT: pp_reg <= pp_reg + 2'd2;
            OP_LINE_END: sub_reg <= sub_reg + 1'b1;
            OP_OUT_ACC: begin
                word_reg[{out_b_reg, 3'b0} +: 8] <=
                    ({1'b0, px} < 9'(w_reg)) ? alpha_of(cov_rd, shift_reg) : 8'd0;
                out_b_reg <= out_b_reg + 1'b1;
            end
            OP_OUT_NEXT: begin
                out_p_reg <= out_p_reg + 1'b1;
                out_b_reg <= '0;
                word_reg  <= '0;
            end
            default: ;
        endcase
    end

    logic [1:0] sub_last;
    assign sub_last = 2'((3'd1 << shift_reg) - 3'd1);

    always_comb begin
        status.render_go  = (s_command == CMD_RENDER) &&
                            ({1'b0, s_row_index} < clip_h_reg) && (w_c != '0);
        status.clr_last   = ({1'b0, clr_reg} == (COV_AW + 1)'(9'(w_reg) - 9'd1));
        status.scan_in    = scan_ptr_reg < point_total_reg;
        status.mark       = rd_m;
        status.hit        = hit_reg;
        status.div_done   = (div_cnt_reg == 6'd39);
        status.cr_full    = (cnt_reg == CR_CW'(NODES_PER_LINE));
        status.ins_zero   = (ins_j_reg == '0);
        status.ins_gt     = cr_rd > v_reg;
        status.edge_last  = (j_reg == end_reg);
        status.pair_ok    = pp_n < cnt_reg;
        status.pix_ok     = u_reg < x2_reg;
        status.last_sub   = (sub_reg == sub_last);
        status.byte_last  = (out_b_reg == 3'd7);
        status.chunk_last = (out_p_reg == chunk_last_reg);
    end

    assign m_alpha_bytes = word_reg;
    assign m_chunk_index = out_p_reg;
    assign m_last_chunk  = (out_p_reg == chunk_last_reg);

endmodule

>>> rtl/scanline_polygon_coverage_rasterizer_top.sv
// Top level of the scanline polygon coverage rasterizer: controller plus datapath.
//
// The block stores outline points of closed paths (signed Q11.8) and renders one pixel
// row of the clip box per render transaction as a burst of 64-bit alpha words, eight
// pixels each, leftmost pixel in the low byte; last_chunk marks the final word. Clear and
// load transactions produce nothing. A render runs to completion before the next
// transaction is taken. It first clears the W entries of the coverage memory (W = row
// width), then for each of the aa subsample lines scans the stored points to find path
// ends, reads each edge, runs three multiply steps and a 40-step radix-2 divider for each
// edge that crosses the line, moves entries for the sorted insertion, and does a
// read-modify-write of the coverage memory for each pixel touched by a span; finally
// it builds each output word from eight read and accumulate pairs, presents it and
// waits for the consumer. The divider and the crossing and coverage memories, each
// with one read and one write port, set the render time. Configuration writes are
// taken at any cycle through cfg_wr_en, but must only be issued while the block is idle.
module scanline_polygon_coverage_rasterizer_top import scpr_pkg::*; #(
    parameter int MAX_POINTS     = DEF_MAX_POINTS,
    parameter int NODES_PER_LINE = DEF_NODES_PER_LINE,
    parameter int SPAN_WIDTH     = DEF_SPAN_WIDTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IW-1:0]         cfg_index,
    input  logic [CFG_DW-1:0]         cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [CMD_W-1:0]          s_command,
    input  logic signed [COORD_W-1:0] s_point_x,
    input  logic signed [COORD_W-1:0] s_point_y,
    input  logic                      s_path_end,
    input  logic [ROW_W-1:0]          s_row_index,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [63:0]               m_alpha_bytes,
    output logic [4:0]                m_chunk_index,
    output logic                      m_last_chunk
);

    dp_op_t     op;
    dp_status_t status;

    // The controller holds only the sequencing state and issues operations; all other state lives in the datapath.
    scpr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .op      (op)
    );

    scpr_datapath #(
        .MAX_POINTS     (MAX_POINTS),
        .NODES_PER_LINE (NODES_PER_LINE),
        .SPAN_WIDTH     (SPAN_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_command     (s_command),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_path_end    (s_path_end),
        .s_row_index   (s_row_index),
        .op            (op),
        .status        (status),
        .m_alpha_bytes (m_alpha_bytes),
        .m_chunk_index (m_chunk_index),
        .m_last_chunk  (m_last_chunk)
    );

endmodule

>>> tb/tb_scanline_polygon_coverage_rasterizer_top.sv
// Self-checking testbench for the scanline polygon coverage rasterizer top level.
`timescale 1ns / 1ps

module tb_scanline_polygon_coverage_rasterizer_top;
    import scpr_pkg::*;

    // The one command code the package leaves unnamed; the block must ignore it.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int MAX_PTS    = DEF_MAX_POINTS;
    localparam int MAX_XINGS  = DEF_NODES_PER_LINE;
    localparam int ROW_PIXELS = DEF_SPAN_WIDTH;
    // Quiet cycles allowed after the last result before the block is treated as idle.
    localparam int SETTLE_CYCLES = 6000;
    // Cycles without any accepted transaction on either channel before giving up.
    localparam int STALL_LIMIT = 400000;
    // Length of the one long receiver hold-off, and the result count that triggers it.
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int HOLDOFF_AT     = 40;

    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      pend;
        logic [ROW_W-1:0]          row;
    } cmd_item_t;

    typedef struct {
        logic [63:0] alpha;
        logic [4:0]  chunk;
        logic        last;
    } alpha_word_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [CFG_IW-1:0]         cfg_index;
    logic [CFG_DW-1:0]         cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic [CMD_W-1:0]          s_command;
    logic signed [COORD_W-1:0] s_point_x;
    logic signed [COORD_W-1:0] s_point_y;
    logic                      s_path_end;
    logic [ROW_W-1:0]          s_row_index;
    logic                      m_valid;
    logic                      m_ready;
    logic [63:0]               m_alpha_bytes;
    logic [4:0]                m_chunk_index;
    logic                      m_last_chunk;

    scanline_polygon_coverage_rasterizer_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_path_end    (s_path_end),
        .s_row_index   (s_row_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_alpha_bytes (m_alpha_bytes),
        .m_chunk_index (m_chunk_index),
        .m_last_chunk  (m_last_chunk)
    );

    // 100 MHz clock.
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Transactions waiting to be offered, and alpha words the block still owes us.
    cmd_item_t   pending_cmds[$];
    alpha_word_t expected_words[$];

    int unsigned error_count;
    int unsigned cmds_accepted;
    int unsigned words_checked;
    int unsigned rows_rendered;
    int unsigned phases_run;

    // ------------------------------------------------------------------
    // Shadow copy of the block: configuration, outline memory and the
    // per-line crossing list used while a row is predicted.
    // ------------------------------------------------------------------
    int unsigned shadow_aa, shadow_clip_x, shadow_clip_y, shadow_clip_w, shadow_clip_h;
    longint      outline_x[MAX_PTS];
    longint      outline_y[MAX_PTS];
    bit          outline_end[MAX_PTS];
    int unsigned outline_count;
    int          line_xings[MAX_XINGS];
    int unsigned line_xing_count;
    int unsigned pixel_cover[ROW_PIXELS];

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    // Rounded quotient with halves going away from zero; den is always positive.
    function automatic longint round_div(input longint num, input longint den);
        if (num >= 0)
            return (2 * num + den) / (2 * den);
        return -((2 * (-num) + den) / (2 * den));
    endfunction

    function automatic int clamp_s16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    // Adds the crossing of edge a-b with subsample line k of the strip, if it has one.
    function automatic void add_edge_crossing(input int unsigned a, input int unsigned b,
                                              input longint strip_q8, input longint k,
                                              input longint aa);
        longint sx, sy, ex, ey, d, dx, syr, eyr, yk, c, syc, kfirst, n, num;
        longint step, half;
        step = 256 / aa;
        half = 128 / aa;
        if (outline_y[a] == outline_y[b]) return;
        if (outline_y[a] < outline_y[b]) begin
            sx = outline_x[a]; sy = outline_y[a]; ex = outline_x[b]; ey = outline_y[b];
        end else begin
            sx = outline_x[b]; sy = outline_y[b]; ex = outline_x[a]; ey = outline_y[a];
        end
        d   = ey - sy;
        dx  = ex - sx;
        syr = sy - strip_q8;
        eyr = ey - strip_q8;
        yk  = half + k * step;
        if (yk < syr || yk >= eyr) return;
        // Clamp the edge start to the strip top, then count the lines crossed so far.
        c      = (syr < 0) ? -syr : 0;
        syc    = (syr < 0) ? 0 : syr;
        kfirst = (syc <= half) ? 0 : (syc - half + step - 1) / step;
        n      = k - kfirst;
        num    = aa * (sx * d + dx * c) + 256 * n * dx;
        // Crossings beyond the list depth are simply dropped.
        if (line_xing_count < MAX_XINGS) begin
            line_xings[line_xing_count] = clamp_s16(round_div(num, 256 * d));
            line_xing_count++;
        end
    endfunction

    // Collects every crossing of one subsample line. Each closed path contributes its
    // closing edge first; points after the last path end belong to no path.
    function automatic void collect_line_crossings(input longint strip_q8, input longint k,
                                                   input longint aa);
        int unsigned first_pt, prev_pt;
        first_pt = 0;
        line_xing_count = 0;
        for (int unsigned i = 0; i < outline_count; i++) begin
            if (outline_end[i]) begin
                prev_pt = i;
                for (int unsigned j = first_pt; j <= i; j++) begin
                    add_edge_crossing(prev_pt, j, strip_q8, k, aa);
                    prev_pt = j;
                end
                first_pt = i + 1;
            end
        end
        for (int unsigned i = 1; i < line_xing_count; i++) begin
            int v;
            int unsigned j;
            v = line_xings[i];
            j = i;
            while (j > 0 && line_xings[j-1] > v) begin
                line_xings[j] = line_xings[j-1];
                j--;
            end
            line_xings[j] = v;
        end
    endfunction

    function automatic logic [7:0] coverage_alpha(input int unsigned cnt, input int unsigned aa);
        int unsigned top;
        top = aa * aa;
        if (cnt >= top) return 8'd255;
        return 8'(cnt * (256 / top));
    endfunction

    // Works out the alpha words of one rendered row and queues them.
    function automatic void predict_row(input int unsigned r);
        int unsigned aa, strip_rows, sub_row, width, chunks;
        longint      strip_q8, lim, x1, x2;
        alpha_word_t w;
        aa = (shadow_aa == 2 || shadow_aa == 4) ? shadow_aa : 1;
        if (r >= shadow_clip_h) return;
        width = (shadow_clip_w < ROW_PIXELS) ? shadow_clip_w : ROW_PIXELS;
        if (width == 0) return;
        chunks     = (width + 7) / 8;
        strip_rows = NODE_LINES / aa;
        strip_q8   = longint'(shadow_clip_y + (r / strip_rows) * strip_rows) * 256;
        sub_row    = r % strip_rows;
        lim        = longint'(width * aa);
        for (int unsigned p = 0; p < ROW_PIXELS; p++) pixel_cover[p] = 0;
        for (int unsigned i = 0; i < aa; i++) begin
            collect_line_crossings(strip_q8, longint'(sub_row * aa + i), longint'(aa));
            // Pair sorted crossings into spans; an odd last crossing is left alone.
            for (int unsigned p = 0; p + 1 < line_xing_count; p += 2) begin
                x1 = longint'(line_xings[p])   - longint'(shadow_clip_x * aa);
                x2 = longint'(line_xings[p+1]) - longint'(shadow_clip_x * aa);
                x1 = (x1 < 0) ? 0 : ((x1 > lim) ? lim : x1);
                x2 = (x2 < 0) ? 0 : ((x2 > lim) ? lim : x2);
                for (longint j = x1; j < x2; j++) pixel_cover[int'(j) / aa]++;
            end
        end
        for (int unsigned p = 0; p < chunks; p++) begin
            w.alpha = '0;
            for (int unsigned b = 0; b < 8; b++) begin
                if (p * 8 + b < width)
                    w.alpha[8*b +: 8] = coverage_alpha(pixel_cover[p*8+b], aa);
            end
            w.chunk = 5'(p);
            w.last  = (p + 1 == chunks);
            expected_words.push_back(w);
        end
        rows_rendered++;
    endfunction

    function automatic void predict_cmd(input cmd_item_t it);
        case (it.cmd)
            CMD_CLEAR: outline_count = 0;
            CMD_LOAD: begin
                // A full outline memory ignores further points.
                if (outline_count < MAX_PTS) begin
                    outline_x[outline_count]   = longint'(it.px);
                    outline_y[outline_count]   = longint'(it.py);
                    outline_end[outline_count] = it.pend;
                    outline_count++;
                end
            end
            CMD_RENDER: predict_row(int'(it.row));
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: sends the pending queue in bursts of random length with random
    // gaps. Valid stays up with a frozen payload until the block takes it.
    // ------------------------------------------------------------------
    cmd_item_t   cur_cmd;
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_cmd(cur_cmd);
                cmds_accepted++;
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    s_command   <= cur_cmd.cmd;
                    s_point_x   <= cur_cmd.px;
                    s_point_y   <= cur_cmd.py;
                    s_path_end  <= cur_cmd.pend;
                    s_row_index <= cur_cmd.row;
                    s_valid     <= 1'b1;
                    if (burst_left == 0) begin
                        // New burst; roughly a third of them run back to back.
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every accepted alpha word against the oldest expected
    // one. The ready pattern cycles through several stall modes, and once in
    // the run the receiver holds off long enough for the block to back up.
    // ------------------------------------------------------------------
    int unsigned monitor_cycle;
    int unsigned holdoff_left;
    bit          holdoff_done;

    always @(posedge aclk) begin
        alpha_word_t exp_w;
        if (!aresetn) begin
            m_ready       <= 1'b0;
            monitor_cycle = 0;
            holdoff_left  = 0;
            holdoff_done  = 1'b0;
        end else begin
            monitor_cycle++;
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected alpha word, chunk %0d", m_chunk_index));
                end else begin
                    exp_w = expected_words.pop_front();
                    if (m_alpha_bytes !== exp_w.alpha)
                        report_mismatch($sformatf("alpha_bytes got %h expected %h (chunk %0d)",
                                                  m_alpha_bytes, exp_w.alpha, exp_w.chunk));
                    if (m_chunk_index !== exp_w.chunk)
                        report_mismatch($sformatf("chunk_index got %0d expected %0d",
                                                  m_chunk_index, exp_w.chunk));
                    if (m_last_chunk !== exp_w.last)
                        report_mismatch($sformatf("last_chunk got %0b expected %0b (chunk %0d)",
                                                  m_last_chunk, exp_w.last, exp_w.chunk));
                end
                words_checked++;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_ready <= 1'b0;
            end else if (!holdoff_done && words_checked == HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
                m_ready      <= 1'b0;
            end else begin
                case (monitor_cycle[9:8])
                    2'd0: m_ready <= 1'b1;
                    2'd1: m_ready <= ($urandom_range(0, 3) != 0);
                    2'd2: m_ready <= monitor_cycle[0];
                    default: m_ready <= ($urandom_range(0, 4) < 2);
                endcase
            end
        end
    end

    // Watchdog: a run that stops moving on both channels is a failure.
    int unsigned quiet_cycles;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    int unsigned phase_cmds;

    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input longint x, input longint y,
                            input logic pend, input logic [ROW_W-1:0] row);
        cmd_item_t it;
        it.cmd  = cmd;
        it.px   = COORD_W'(x);
        it.py   = COORD_W'(y);
        it.pend = pend;
        it.row  = row;
        pending_cmds.push_back(it);
        phase_cmds++;
    endtask

    function automatic longint clamp_coord(input longint v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    function automatic longint pick(input longint lo, input longint hi);
        return lo + longint'($urandom_range(0, int'(hi - lo)));
    endfunction

    function automatic logic [ROW_W-1:0] rand_row();
        return ROW_W'($urandom);
    endfunction

    // Pixel heights used for placing shapes and choosing rows in the current setup.
    function automatic int unsigned box_rows();
        return (shadow_clip_h < 40) ? ((shadow_clip_h == 0) ? 1 : shadow_clip_h) : 40;
    endfunction

    // Loads one closed path of n points scattered around the clip box.
    task automatic load_path(input int unsigned n);
        longint x, y, prev_y;
        int unsigned width;
        width  = (shadow_clip_w < ROW_PIXELS) ? shadow_clip_w : ROW_PIXELS;
        prev_y = 0;
        for (int unsigned k = 0; k < n; k++) begin
            x = clamp_coord(longint'(shadow_clip_x) * 256 +
                            pick(-1024, longint'(width) * 256 + 1024));
            y = clamp_coord(longint'(shadow_clip_y) * 256 +
                            pick(-512, longint'(box_rows()) * 256 + 512));
            // Now and then repeat the previous y to make a horizontal edge.
            if (k > 0 && $urandom_range(0, 5) == 0) y = prev_y;
            prev_y = y;
            push_cmd(CMD_LOAD, x, y, (k == n - 1), rand_row());
        end
    endtask

    task automatic push_render(input logic [ROW_W-1:0] row);
        push_cmd(CMD_RENDER, longint'($urandom), longint'($urandom), 1'($urandom), row);
    endtask

    // Waits until the block owes nothing, then lets it settle.
    task automatic wait_block_idle();
        while (pending_cmds.size() != 0 || s_valid || expected_words.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DW'(val);
        case (idx)
            CFG_AA_LEVEL: shadow_aa     = val & 32'h7;
            CFG_CLIP_X:   shadow_clip_x = val & 32'h7FF;
            CFG_CLIP_Y:   shadow_clip_y = val & 32'h7FF;
            CFG_CLIP_W:   shadow_clip_w = val & 32'h1FF;
            CFG_CLIP_H:   shadow_clip_h = val & 32'h7FF;
            default: ;
        endcase
    endtask

    task automatic setup_box(input int unsigned aa, input int unsigned cx, input int unsigned cy,
                             input int unsigned cw, input int unsigned ch);
        wait_block_idle();
        write_reg(CFG_AA_LEVEL, aa);
        write_reg(CFG_CLIP_X, cx);
        write_reg(CFG_CLIP_Y, cy);
        write_reg(CFG_CLIP_W, cw);
        write_reg(CFG_CLIP_H, ch);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        phase_cmds = 0;
        phases_run++;
    endtask

    // Mostly well-formed scenes (clear, closed paths, renders) with random content,
    // mixed with noise commands, unclosed point runs and out-of-box rows.
    task automatic random_scenes(input int unsigned budget);
        int unsigned kind;
        while (phase_cmds < budget) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                push_cmd(CMD_CLEAR, longint'($urandom), longint'($urandom), 1'($urandom),
                         rand_row());
                repeat ($urandom_range(1, 2)) load_path($urandom_range(1, 7));
                repeat ($urandom_range(1, 3))
                    push_render(ROW_W'($urandom_range(0, box_rows() - 1)));
            end else if (kind == 7) begin
                push_cmd(($urandom_range(0, 1) == 0) ? CMD_UNUSED : CMD_LOAD,
                         longint'($urandom), longint'($urandom), 1'($urandom), rand_row());
            end else if (kind == 8) begin
                repeat ($urandom_range(1, 3))
                    push_cmd(CMD_LOAD, longint'($urandom), longint'($urandom), 1'b0, rand_row());
                push_render(ROW_W'($urandom_range(0, box_rows() - 1)));
            end else begin
                push_render(rand_row());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_command     = CMD_CLEAR;
        s_point_x     = '0;
        s_point_y     = '0;
        s_path_end    = 1'b0;
        s_row_index   = '0;
        m_ready       = 1'b0;
        error_count   = 0;
        cmds_accepted = 0;
        words_checked = 0;
        rows_rendered = 0;
        phases_run    = 0;
        quiet_cycles  = 0;
        shadow_aa     = 1;
        shadow_clip_x = 0;
        shadow_clip_y = 0;
        shadow_clip_w = 0;
        shadow_clip_h = 0;
        outline_count = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed scene in a small 24 x 32 box at 2x subsampling.
        setup_box(2, 16, 8, 24, 32);
        push_cmd(CMD_CLEAR, 0, 0, 1'b0, '0);
        push_cmd(CMD_LOAD, 17 * 256 + 128, 8 * 256 + 64, 1'b0, '0);
        push_cmd(CMD_LOAD, 38 * 256, 20 * 256 + 200, 1'b0, '0);
        push_cmd(CMD_LOAD, 20 * 256 + 77, 39 * 256 + 255, 1'b1, '0);
        // Rectangle: two of its edges are horizontal and contribute nothing.
        push_cmd(CMD_LOAD, 18 * 256, 10 * 256, 1'b0, '0);
        push_cmd(CMD_LOAD, 30 * 256, 10 * 256, 1'b0, '0);
        push_cmd(CMD_LOAD, 30 * 256, 20 * 256, 1'b0, '0);
        push_cmd(CMD_LOAD, 18 * 256, 20 * 256, 1'b1, '0);
        // A single-point path.
        push_cmd(CMD_LOAD, 25 * 256, 12 * 256, 1'b1, '0);
        push_render(10'd0);
        push_render(10'd5);
        push_render(10'd31);
        // Rows at or past the box height render nothing.
        push_render(10'd32);
        push_render(10'd1023);
        // A huge triangle reaching the coordinate extremes.
        push_cmd(CMD_LOAD, -524288, -524288, 1'b0, '0);
        push_cmd(CMD_LOAD, 524287, 524287, 1'b0, '0);
        push_cmd(CMD_LOAD, -524288, 524287, 1'b1, 10'd1023);
        // Trailing points with no path end are not part of any path.
        push_cmd(CMD_LOAD, 16 * 256, 8 * 256, 1'b0, '0);
        push_cmd(CMD_LOAD, 40 * 256, 30 * 256, 1'b0, '0);
        push_render(10'd12);
        push_cmd(CMD_UNUSED, -1, -1, 1'b1, 10'd1023);
        push_cmd(CMD_CLEAR, 0, 0, 1'b0, '0);
        push_render(10'd12);

        setup_box(4, 100, 40, 64, 48);
        random_scenes(24);
        setup_box(1, 0, 0, 256, 1024);
        random_scenes(24);
        setup_box(3, 2047, 2047, 511, 2047);
        random_scenes(20);
        setup_box(2, 500, 300, 37, 20);
        random_scenes(24);
        setup_box(0, 3, 5, 8, 64);
        random_scenes(20);
        setup_box(7, 1000, 1000, 200, 96);
        random_scenes(24);
        setup_box(4, 0, 0, 0, 0);
        random_scenes(8);

        // Zigzag path with far more crossings per line than the list holds, followed
        // by two single-point paths.
        setup_box(4, 0, 0, 256, 16);
        push_cmd(CMD_CLEAR, 0, 0, 1'b0, '0);
        for (int k = 0; k < 80; k++)
            push_cmd(CMD_LOAD, longint'(k) * 700 + 300, (k % 2 == 0) ? 256 : 15 * 256 + 100,
                     (k == 79), rand_row());
        push_cmd(CMD_LOAD, 100 * 256, 2 * 256, 1'b1, '0);
        push_cmd(CMD_LOAD, 10 * 256, 14 * 256, 1'b1, '0);
        push_render(10'd0);
        push_render(10'd7);
        push_render(10'd15);
        push_render(10'd16);

        wait_block_idle();
        $display("Covered %0d transactions over %0d box setups;", cmds_accepted, phases_run);
        $display("%0d rows rendered, %0d words checked.", rows_rendered, words_checked);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches found.", error_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
